@@ rtl/tsps_pkg.sv @@
// ----------------------------------------------------------------------------
// tsps_pkg
// Types, codes and constants shared by the step profile sequencer files.
// ----------------------------------------------------------------------------
package tsps_pkg;

  // Default sizing of the step table and the ramp rate (tenths of a degree per
  // minute).
  localparam int unsigned MAX_STEPS_DEF        = 64;
  localparam int unsigned RAMP_RATE_TENTHS_DEF = 25;

  // Seconds in ten minutes, used to scale a temperature change into ramp time.
  localparam int unsigned SECONDS_PER_TEN_MIN = 600;
  // Largest ramp length that the ramp counter holds.
  localparam int unsigned RAMP_MAX            = 8191;
  localparam int unsigned RAMP_W              = 13;
  // Number of absolute temperature differences (8-bit magnitude).
  localparam int unsigned TEMP_DIFF_CNT       = 256;

  // Item kinds carried in the input tuser.
  typedef enum logic [1:0] {
    FN_TICK    = 2'd0,
    FN_WRITE   = 2'd1,
    FN_RESTART = 2'd2,
    FN_NOP     = 2'd3
  } func_e;

  // One step of the profile, temperature in the lowest bits.
  typedef struct packed {
    logic [7:0]        off_time;
    logic [7:0]        on_time;
    logic              cycle_en;
    logic [15:0]       duration;
    logic signed [7:0] temperature;
  } step_entry_t;

  // Item sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CUR,
    ST_NEXT,
    ST_LOAD,
    ST_EMIT
  } seq_state_e;

endpackage

@@ rtl/tsps_step_mem.sv @@
// ----------------------------------------------------------------------------
// tsps_step_mem
// Step table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tsps_step_mem #(
  parameter int unsigned DEPTH = tsps_pkg::MAX_STEPS_DEF
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [$clog2(DEPTH)-1:0]  waddr_i,
  input  tsps_pkg::step_entry_t     wdata_i,
  input  logic                      re_i,
  input  logic [$clog2(DEPTH)-1:0]  raddr_i,
  output tsps_pkg::step_entry_t     rdata_o
);

  tsps_pkg::step_entry_t mem [DEPTH];
  tsps_pkg::step_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/timed_step_profile_sequencer_top.sv @@
// ----------------------------------------------------------------------------
// timed_step_profile_sequencer_top
// Runs a loaded table of test steps, one tick per second.
// ----------------------------------------------------------------------------
// An input transfer carries one item: a one-second tick, a table write or a
// restart (kind in s_axis_tuser). Every item returns exactly one status
// transfer on the master side, showing the state after the item. A one-entry
// input buffer and a result register decouple the two sides, so a new item is
// taken while the previous status still waits. Items are worked in order by a
// small sequencer around the step table memory (one write port, one read port,
// registered read): a write, a no-op, a ramp tick or a tick after the end go
// straight to emit, a counting tick via the current step state, a tick that
// moves on via the current and next step states (two table reads: the current
// and the next step), a restart via the load state. Emit waits for a free
// result register. The ramp between steps is |temperature change| * 600 /
// RAMP_RATE_TENTHS seconds, capped at 8191, looked up in a table built at
// elaboration. The step table has no reset; run steps only after they are
// written. Write step_count only while the block is idle (not enforced).
// ----------------------------------------------------------------------------
module timed_step_profile_sequencer_top #(
  parameter int unsigned MAX_STEPS        = tsps_pkg::MAX_STEPS_DEF,
  parameter int unsigned RAMP_RATE_TENTHS = tsps_pkg::RAMP_RATE_TENTHS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // step_count register
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: entry_index[5:0], entry_temperature[13:6], entry_duration[29:14],
  //        entry_cycle_en[30], entry_on_time[38:31], entry_off_time[46:39],
  //        zero[47]
  input  logic [47:0] s_axis_tdata,
  // tuser: func[1:0]
  input  logic [1:0]  s_axis_tuser,
  // status results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: out_level[0], test_done[1], ramping[2], step_number[8:3],
  //        step_starting[9], seconds_left[25:10], ramp_left[38:26], zero[39]
  output logic [39:0] m_axis_tdata
);

  localparam int unsigned PW = $clog2(MAX_STEPS);
  localparam int unsigned RW = tsps_pkg::RAMP_W;

  // --------------------------------------------------------------------------
  // Ramp length table, one entry per absolute temperature difference.
  // --------------------------------------------------------------------------
  logic [RW-1:0] ramp_lut [tsps_pkg::TEMP_DIFF_CNT];

  for (genvar k = 0; k < tsps_pkg::TEMP_DIFF_CNT; k++) begin : g_ramp_lut
    localparam int unsigned RAMP_LEN =
      (k * tsps_pkg::SECONDS_PER_TEN_MIN) / RAMP_RATE_TENTHS;
    assign ramp_lut[k] = (RAMP_LEN > tsps_pkg::RAMP_MAX) ?
                         RW'(tsps_pkg::RAMP_MAX) : RW'(RAMP_LEN);
  end

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  logic [6:0] step_count_q;
  logic [PW:0] eff_count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_count_q <= 7'd1;
    end else if (cfg_we_i) begin
      step_count_q <= cfg_wdata_i;
    end
  end

  // Clamp the step count into 1..MAX_STEPS.
  always_comb begin
    priority if (step_count_q == 7'd0) begin
      eff_count = (PW + 1)'(1);
    end else if (32'(step_count_q) > MAX_STEPS) begin
      eff_count = (PW + 1)'(MAX_STEPS);
    end else begin
      eff_count = (PW + 1)'(step_count_q);
    end
  end

  // --------------------------------------------------------------------------
  // Input buffer: hold one item until the sequencer takes it.
  // --------------------------------------------------------------------------
  logic                  in_valid_q;
  logic [47:0]           in_data_q;
  tsps_pkg::func_e       in_func_q;
  logic                  in_pop;
  logic [5:0]            in_index;
  tsps_pkg::step_entry_t in_entry;

  assign s_axis_tready = !in_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (in_pop) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_data_q <= s_axis_tdata;
      in_func_q <= tsps_pkg::func_e'(s_axis_tuser);
    end
  end

  assign in_index             = in_data_q[5:0];
  assign in_entry.temperature = in_data_q[13:6];
  assign in_entry.duration    = in_data_q[29:14];
  assign in_entry.cycle_en    = in_data_q[30];
  assign in_entry.on_time     = in_data_q[38:31];
  assign in_entry.off_time    = in_data_q[46:39];

  // --------------------------------------------------------------------------
  // Step table
  // --------------------------------------------------------------------------
  logic                  mem_we;
  logic                  mem_re;
  logic [PW-1:0]         mem_raddr;
  tsps_pkg::step_entry_t mem_rdata;

  tsps_step_mem #(
    .DEPTH(MAX_STEPS)
  ) u_step_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(PW'(in_index)),
    .wdata_i(in_entry),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // --------------------------------------------------------------------------
  // Sequencer state
  // --------------------------------------------------------------------------
  tsps_pkg::seq_state_e state_q, state_d;

  logic [PW-1:0]     ptr_q, ptr_d;
  logic [RW-1:0]     ramp_q, ramp_d;
  logic [15:0]       dur_q, dur_d;
  logic [7:0]        on_q, on_d;
  logic [7:0]        off_q, off_d;
  logic              level_q, level_d;
  logic              fin_q, fin_d;
  logic              ramp_flag_q, ramp_flag_d;
  logic              start_flag_q, start_flag_d;
  logic signed [7:0] cur_temp_q, cur_temp_d;

  logic              out_valid_q;
  logic [39:0]       out_data_q;
  logic              out_free;
  logic              out_load;

  logic              dur_expired;
  logic              last_step;
  logic [PW:0]       ptr_inc;
  logic signed [8:0] temp_diff;
  logic [7:0]        temp_mag;

  assign out_free    = !out_valid_q || m_axis_tready;
  assign dur_expired = (dur_q <= 16'd1);
  assign ptr_inc     = {1'b0, ptr_q} + (PW + 1)'(1);
  assign last_step   = (ptr_inc >= eff_count);

  // Temperature change between the step just left and the one just read.
  assign temp_diff = {mem_rdata.temperature[7], mem_rdata.temperature} -
                     {cur_temp_q[7], cur_temp_q};
  assign temp_mag  = temp_diff[8] ? 8'(-temp_diff) : 8'(temp_diff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= tsps_pkg::ST_IDLE;
      ptr_q        <= '0;
      ramp_q       <= '0;
      dur_q        <= '0;
      on_q         <= '0;
      off_q        <= '0;
      level_q      <= 1'b0;
      fin_q        <= 1'b0;
      ramp_flag_q  <= 1'b0;
      start_flag_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      ptr_q        <= ptr_d;
      ramp_q       <= ramp_d;
      dur_q        <= dur_d;
      on_q         <= on_d;
      off_q        <= off_d;
      level_q      <= level_d;
      fin_q        <= fin_d;
      ramp_flag_q  <= ramp_flag_d;
      start_flag_q <= start_flag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_temp_q <= cur_temp_d;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tsps_pkg::ST_IDLE: begin
        if (in_valid_q) begin
          unique case (in_func_q)
            tsps_pkg::FN_TICK: begin
              state_d = (fin_q || (ramp_q != '0)) ? tsps_pkg::ST_EMIT : tsps_pkg::ST_CUR;
            end
            tsps_pkg::FN_RESTART: state_d = tsps_pkg::ST_LOAD;
            default:              state_d = tsps_pkg::ST_EMIT;
          endcase
        end
      end
      tsps_pkg::ST_CUR: begin
        state_d = (dur_expired && !last_step) ? tsps_pkg::ST_NEXT : tsps_pkg::ST_EMIT;
      end
      tsps_pkg::ST_NEXT: state_d = tsps_pkg::ST_EMIT;
      tsps_pkg::ST_LOAD: state_d = tsps_pkg::ST_EMIT;
      tsps_pkg::ST_EMIT: begin
        if (out_free) begin
          state_d = tsps_pkg::ST_IDLE;
        end
      end
      default: state_d = tsps_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    ptr_d        = ptr_q;
    ramp_d       = ramp_q;
    dur_d        = dur_q;
    on_d         = on_q;
    off_d        = off_q;
    level_d      = level_q;
    fin_d        = fin_q;
    ramp_flag_d  = ramp_flag_q;
    start_flag_d = start_flag_q;
    cur_temp_d   = cur_temp_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_raddr    = ptr_q;
    in_pop       = 1'b0;
    out_load     = 1'b0;

    unique case (state_q)
      tsps_pkg::ST_IDLE: begin
        if (in_valid_q) begin
          in_pop       = 1'b1;
          ramp_flag_d  = 1'b0;
          start_flag_d = 1'b0;
          unique case (in_func_q)
            tsps_pkg::FN_TICK: begin
              // Spend ramp time first; otherwise fetch the current step.
              if (!fin_q) begin
                if (ramp_q != '0) begin
                  ramp_d      = ramp_q - RW'(1);
                  ramp_flag_d = 1'b1;
                end else begin
                  mem_re = 1'b1;
                end
              end
            end
            tsps_pkg::FN_WRITE: begin
              // Drop writes beyond the table.
              mem_we = (32'(in_index) < MAX_STEPS);
            end
            tsps_pkg::FN_RESTART: begin
              ptr_d     = '0;
              ramp_d    = '0;
              fin_d     = 1'b0;
              level_d   = 1'b0;
              mem_re    = 1'b1;
              mem_raddr = '0;
            end
            default: ;
          endcase
        end
      end

      tsps_pkg::ST_CUR: begin
        start_flag_d = (dur_q == mem_rdata.duration);
        if (dur_expired) begin
          dur_d = '0;
          if (last_step) begin
            fin_d   = 1'b1;
            level_d = 1'b0;
          end else begin
            // Advance and fetch the next step.
            ptr_d      = ptr_inc[PW-1:0];
            cur_temp_d = mem_rdata.temperature;
            mem_re     = 1'b1;
            mem_raddr  = ptr_inc[PW-1:0];
          end
        end else begin
          dur_d = dur_q - 16'd1;
          if (mem_rdata.cycle_en) begin
            if (!level_q) begin
              if (off_q <= 8'd1) begin
                off_d   = mem_rdata.off_time;
                level_d = 1'b1;
              end else begin
                off_d = off_q - 8'd1;
              end
            end else begin
              if (on_q <= 8'd1) begin
                on_d    = mem_rdata.on_time;
                level_d = 1'b0;
              end else begin
                on_d = on_q - 8'd1;
              end
            end
          end
        end
      end

      tsps_pkg::ST_NEXT: begin
        ramp_d  = ramp_lut[temp_mag];
        dur_d   = mem_rdata.duration;
        on_d    = mem_rdata.on_time;
        off_d   = mem_rdata.off_time;
        level_d = 1'b0;
      end

      tsps_pkg::ST_LOAD: begin
        dur_d = mem_rdata.duration;
        on_d  = mem_rdata.on_time;
        off_d = mem_rdata.off_time;
      end

      tsps_pkg::ST_EMIT: begin
        out_load = out_free;
      end

      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {1'b0, ramp_q, dur_q, start_flag_q, 6'(ptr_q),
                     ramp_flag_q, fin_q, level_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
